/* rtl/pss_pkg.sv */
package pss_pkg;

   localparam int unsigned AngleWidth = 12;
   localparam int unsigned RangeWidth = 11;
   localparam int unsigned LevelWidth = 7;
   localparam int unsigned TickWidth  = 16;
   localparam int unsigned DriveWidth = 8;
   localparam int unsigned PhaseWidth = 4;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned CsrDataWidth = 16;
   // signed threshold width: holds center+range and center-range
   localparam int unsigned ThreshWidth = 14;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_UPRIGHT_ANGLE  = 3'd0,
      CSR_BAND_OFFSET    = 3'd1,
      CSR_KICK_LEVEL     = 3'd2,
      CSR_KICK_TICKS     = 3'd3,
      CSR_SAMPLE_DIVIDER = 3'd4
   } csr_index_type;

   localparam logic [AngleWidth-1:0] UprightAngleReset  = 12'd2048;
   localparam logic [RangeWidth-1:0] BandOffsetReset    = 11'd500;
   localparam logic [LevelWidth-1:0] KickLevelReset     = 7'd35;
   localparam logic [TickWidth-1:0]  KickTicksReset     = 16'd100;
   localparam logic [TickWidth-1:0]  SampleDividerReset = 16'd40;

   typedef enum logic [PhaseWidth-1:0] {
      PH_STOP   = 4'd0,
      PH_WATCH  = 4'd1,
      PH_R_KICK = 4'd2,
      PH_R_HOLD = 4'd3,
      PH_R_BACK = 4'd4,
      PH_R_TAIL = 4'd5,
      PH_L_KICK = 4'd6,
      PH_L_HOLD = 4'd7,
      PH_L_BACK = 4'd8,
      PH_L_TAIL = 4'd9
   } phase_type;

   typedef struct packed {
      logic [AngleWidth-1:0] upright_angle;
      logic [RangeWidth-1:0] band_offset;
      logic [LevelWidth-1:0] kick_level;
      logic [TickWidth-1:0]  kick_ticks;
      logic [TickWidth-1:0]  sample_divider;
   } cfg_type;

   typedef struct packed {
      logic signed [DriveWidth-1:0] motor_drive;
      logic                         drive_written;
      logic [PhaseWidth-1:0]        run_phase;
   } result_type;

endpackage

/* rtl/pendulum_swing_up_sequencer_unit.sv */
// flow: an accepted word waits in the input register and moves to the result register
// when the result slot is free; throughput: one word per cycle while rsp_stall is low;
// input, phase logic and result form one pass; a stalled result holds the input register
// reset: synchronous, active high; clears both valid flags, sets phase to stopped,
// clears counters, history and drive, and loads the register defaults
module pendulum_swing_up_sequencer_unit
   import pss_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [AngleWidth-1:0]        req_angle,
   input  logic                         req_start_stop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DriveWidth-1:0] rsp_motor_drive,
   output logic                         rsp_drive_written,
   output logic [PhaseWidth-1:0]        rsp_run_phase,
   input  logic                         csr_write_enable,
   input  logic [CsrIdxWidth-1:0]       csr_index,
   input  logic [CsrDataWidth-1:0]      csr_data
);

   cfg_type    cfg;
   result_type result;

   logic                  in_valid_ff, in_valid_in;
   logic [AngleWidth-1:0] angle_ff;
   logic                  toggle_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_ff;
   logic                  advance;
   logic                  step;
   logic                  req_take;

   pss_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cfg              (cfg)
   );

   pss_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .angle  (angle_ff),
      .toggle (toggle_ff),
      .cfg    (cfg),
      .result (result)
   );

   // result slot is free or drains this cycle
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = step || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         angle_ff  <= req_angle;
         toggle_ff <= req_start_stop;
      end
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_motor_drive   = rsp_ff.motor_drive;
   assign rsp_drive_written = rsp_ff.drive_written;
   assign rsp_run_phase     = rsp_ff.run_phase;

   a_hold_word: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(angle_ff) && $stable(toggle_ff))
      else $error("pending input word lost");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !step)
      else $error("stalled result overwritten");

   a_step_valid: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("processed word produced no result");

endmodule

/* rtl/pss_csr.sv */
module pss_csr
   import pss_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_data,
   output cfg_type                 cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_UPRIGHT_ANGLE:  cfg_in.upright_angle  = csr_data[AngleWidth-1:0];
            CSR_BAND_OFFSET:    cfg_in.band_offset    = csr_data[RangeWidth-1:0];
            CSR_KICK_LEVEL:     cfg_in.kick_level     = csr_data[LevelWidth-1:0];
            CSR_KICK_TICKS:     cfg_in.kick_ticks     = csr_data[TickWidth-1:0];
            CSR_SAMPLE_DIVIDER: cfg_in.sample_divider = csr_data[TickWidth-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.upright_angle  <= UprightAngleReset;
         cfg_ff.band_offset    <= BandOffsetReset;
         cfg_ff.kick_level     <= KickLevelReset;
         cfg_ff.kick_ticks     <= KickTicksReset;
         cfg_ff.sample_divider <= SampleDividerReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/pss_core.sv */
module pss_core
   import pss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [AngleWidth-1:0] angle,
   input  logic                  toggle,
   input  cfg_type               cfg,
   output result_type            result
);

   phase_type                    phase_ff, phase_in, phase_v;
   logic [TickWidth-1:0]         sample_ff, sample_in;
   logic [TickWidth-1:0]         pulse_ff, pulse_in;
   // the oldest history entry is only needed at the compare, so two are kept
   logic [AngleWidth-1:0]        hist_ff [2];
   logic [AngleWidth-1:0]        hist_in [2];
   logic signed [DriveWidth-1:0] drive_ff, drive_in;
   logic                         wrote;

   logic [TickWidth-1:0]          sample_inc;
   logic [TickWidth-1:0]          pulse_dec;
   logic signed [ThreshWidth-1:0] hi, lo, h0, h1, h2;
   logic                          peak_hi, peak_lo;
   logic signed [DriveWidth-1:0]  kick_pos, kick_neg;

   assign sample_inc = sample_ff + 16'd1;
   assign pulse_dec  = pulse_ff - 16'd1;
   assign hi = $signed({2'b00, cfg.upright_angle}) + $signed({3'b000, cfg.band_offset});
   assign lo = $signed({2'b00, cfg.upright_angle}) - $signed({3'b000, cfg.band_offset});
   // history after the shift: newest is this tick's angle
   assign h0 = $signed({2'b00, angle});
   assign h1 = $signed({2'b00, hist_ff[0]});
   assign h2 = $signed({2'b00, hist_ff[1]});
   assign peak_hi = (h0 > hi) && (h1 > hi) && (h2 > hi) && (h1 < h0) && (h1 < h2);
   assign peak_lo = (h0 < lo) && (h1 < lo) && (h2 < lo) && (h1 > h0) && (h1 > h2);
   assign kick_pos = $signed({1'b0, cfg.kick_level});
   assign kick_neg = -kick_pos;

   always_comb begin
      phase_v = phase_ff;
      if (toggle) begin
         phase_v = (phase_ff == PH_STOP) ? PH_WATCH : PH_STOP;
      end
      phase_in  = phase_v;
      sample_in = sample_ff;
      pulse_in  = pulse_ff;
      hist_in   = hist_ff;
      drive_in  = drive_ff;
      wrote     = 1'b0;
      unique case (phase_v)
         PH_STOP: begin
            drive_in = '0;
            wrote    = 1'b1;
         end
         PH_WATCH: begin
            sample_in = sample_inc;
            if (sample_inc >= cfg.sample_divider) begin
               sample_in  = '0;
               hist_in[0] = angle;
               hist_in[1] = hist_ff[0];
               // left kick wins when both sides match
               if (peak_lo) begin
                  phase_in = PH_L_KICK;
               end else if (peak_hi) begin
                  phase_in = PH_R_KICK;
               end
            end
         end
         PH_R_KICK, PH_L_BACK: begin
            drive_in = kick_pos;
            wrote    = 1'b1;
            pulse_in = cfg.kick_ticks;
            phase_in = (phase_v == PH_R_KICK) ? PH_R_HOLD : PH_L_TAIL;
         end
         PH_R_BACK, PH_L_KICK: begin
            drive_in = kick_neg;
            wrote    = 1'b1;
            pulse_in = cfg.kick_ticks;
            phase_in = (phase_v == PH_R_BACK) ? PH_R_TAIL : PH_L_HOLD;
         end
         PH_R_HOLD, PH_L_HOLD: begin
            pulse_in = pulse_dec;
            if (pulse_dec == '0) begin
               phase_in = (phase_v == PH_R_HOLD) ? PH_R_BACK : PH_L_BACK;
            end
         end
         PH_R_TAIL, PH_L_TAIL: begin
            pulse_in = pulse_dec;
            if (pulse_dec == '0) begin
               drive_in = '0;
               wrote    = 1'b1;
               phase_in = PH_WATCH;
            end
         end
         default: begin
            phase_in = phase_v;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_STOP;
         sample_ff  <= '0;
         pulse_ff   <= '0;
         hist_ff[0] <= '0;
         hist_ff[1] <= '0;
         drive_ff   <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         sample_ff <= sample_in;
         pulse_ff  <= pulse_in;
         hist_ff   <= hist_in;
         drive_ff  <= drive_in;
      end
   end

   assign result.motor_drive   = drive_in;
   assign result.drive_written = wrote;
   assign result.run_phase     = phase_in;

   // stop and watch never hold a drive level
   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_STOP |-> drive_ff == '0)
      else $error("drive not zero while stopped");

   a_watch_zero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_WATCH |-> drive_ff == '0)
      else $error("drive not zero while watching");

   a_kick_to_hold: assert property (@(posedge clock) disable iff (reset)
      step && !toggle && phase_ff == PH_R_KICK |=> phase_ff == PH_R_HOLD)
      else $error("right kick did not move to hold");

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;
   import pss_pkg::*;

   localparam int QuietLimit    = 200;
   localparam int PhaseCount    = 9;
   localparam int TicksPerPhase = 65;
   localparam int RowCount      = 17;

   typedef struct packed {
      logic [AngleWidth-1:0] angle;
      logic                  toggle;
      logic                  typed;
      result_type            want;
   } tick_row_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [AngleWidth-1:0]        req_angle;
   logic                         req_start_stop;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic signed [DriveWidth-1:0] rsp_motor_drive;
   logic                         rsp_drive_written;
   logic [PhaseWidth-1:0]        rsp_run_phase;
   logic                         csr_write_enable;
   logic [CsrIdxWidth-1:0]       csr_index;
   logic [CsrDataWidth-1:0]      csr_data;

   // sequencer state as the testbench sees it
   cfg_type                      cfg_now;
   phase_type                    sw_phase;
   logic [TickWidth-1:0]         sample_ticks;
   logic [TickWidth-1:0]         pulse_left;
   logic [AngleWidth-1:0]        angle_hist [3];
   logic signed [DriveWidth-1:0] drive_now;

   result_type            pending_words [$];
   logic [AngleWidth-1:0] swing_plan [$];
   tick_row_type          swing_rows [RowCount];

   bit idle_on;
   bit stall_bursts_on;
   int mismatches;
   int ticks_sent;
   int words_checked;
   int drive_pulses;
   int quiet_cycles;

   pendulum_swing_up_sequencer_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_angle         (req_angle),
      .req_start_stop    (req_start_stop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_motor_drive   (rsp_motor_drive),
      .rsp_drive_written (rsp_drive_written),
      .rsp_run_phase     (rsp_run_phase),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic cfg_type make_settings(input int ca, input int cr, input int kl,
                                             input int kt, input int sd);
      cfg_type c;
      c.upright_angle  = ca[AngleWidth-1:0];
      c.band_offset    = cr[RangeWidth-1:0];
      c.kick_level     = kl[LevelWidth-1:0];
      c.kick_ticks     = kt[TickWidth-1:0];
      c.sample_divider = sd[TickWidth-1:0];
      return c;
   endfunction

   // one tick of the sequencer: toggle first, then the phase step
   function automatic result_type predict_tick(input logic [AngleWidth-1:0] angle,
                                               input logic toggle);
      result_type r;
      logic written;
      logic signed [DriveWidth-1:0] kick;
      int hi, lo, h0, h1, h2;
      written = 1'b0;
      kick = signed'({1'b0, cfg_now.kick_level});
      hi = int'(cfg_now.upright_angle) + int'(cfg_now.band_offset);
      lo = int'(cfg_now.upright_angle) - int'(cfg_now.band_offset);
      if (toggle)
         sw_phase = (sw_phase == PH_STOP) ? PH_WATCH : PH_STOP;
      case (sw_phase)
         PH_STOP: begin
            drive_now = '0;
            written = 1'b1;
         end
         PH_WATCH: begin
            sample_ticks = sample_ticks + 16'd1;
            if (sample_ticks >= cfg_now.sample_divider) begin
               sample_ticks = '0;
               angle_hist[2] = angle_hist[1];
               angle_hist[1] = angle_hist[0];
               angle_hist[0] = angle;
               h0 = int'(angle_hist[0]);
               h1 = int'(angle_hist[1]);
               h2 = int'(angle_hist[2]);
               // turning point beyond the band, left side checked last so it wins
               if (h0 > hi && h1 > hi && h2 > hi && h1 < h0 && h1 < h2)
                  sw_phase = PH_R_KICK;
               if (h0 < lo && h1 < lo && h2 < lo && h1 > h0 && h1 > h2)
                  sw_phase = PH_L_KICK;
            end
         end
         PH_R_KICK, PH_L_BACK: begin
            drive_now = kick;
            written = 1'b1;
            pulse_left = cfg_now.kick_ticks;
            sw_phase = (sw_phase == PH_R_KICK) ? PH_R_HOLD : PH_L_TAIL;
         end
         PH_R_BACK, PH_L_KICK: begin
            drive_now = -kick;
            written = 1'b1;
            pulse_left = cfg_now.kick_ticks;
            sw_phase = (sw_phase == PH_R_BACK) ? PH_R_TAIL : PH_L_HOLD;
         end
         PH_R_HOLD, PH_L_HOLD: begin
            pulse_left = pulse_left - 16'd1;
            if (pulse_left == '0)
               sw_phase = (sw_phase == PH_R_HOLD) ? PH_R_BACK : PH_L_BACK;
         end
         PH_R_TAIL, PH_L_TAIL: begin
            pulse_left = pulse_left - 16'd1;
            if (pulse_left == '0) begin
               drive_now = '0;
               written = 1'b1;
               sw_phase = PH_WATCH;
            end
         end
         default: begin
         end
      endcase
      r.motor_drive = drive_now;
      r.drive_written = written;
      r.run_phase = sw_phase;
      return r;
   endfunction

   // angles for the history: mostly planned turning points beyond the band
   function automatic logic [AngleWidth-1:0] next_swing_sample();
      int hi, lo, peak;
      bit go_left;
      hi = int'(cfg_now.upright_angle) + int'(cfg_now.band_offset);
      lo = int'(cfg_now.upright_angle) - int'(cfg_now.band_offset);
      if (swing_plan.size() == 0) begin
         if (hi > 4093 && lo < 2) begin
            swing_plan.push_back(AngleWidth'($urandom_range(0, 4095)));
         end else begin
            go_left = (hi > 4093) || (lo >= 2 && $urandom_range(0, 1) == 1);
            if (go_left) begin
               peak = $urandom_range(1, lo - 1);
               swing_plan.push_back(AngleWidth'($urandom_range(0, peak - 1)));
               swing_plan.push_back(AngleWidth'(peak));
               swing_plan.push_back(AngleWidth'($urandom_range(0, peak - 1)));
            end else begin
               peak = $urandom_range(hi + 1, 4094);
               swing_plan.push_back(AngleWidth'($urandom_range(peak + 1, 4095)));
               swing_plan.push_back(AngleWidth'(peak));
               swing_plan.push_back(AngleWidth'($urandom_range(peak + 1, 4095)));
            end
         end
      end
      return swing_plan.pop_front();
   endfunction

   task automatic send_tick(input logic [AngleWidth-1:0] angle, input logic toggle,
                            input logic typed, input result_type typed_word);
      int gap;
      result_type predicted;
      gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_angle = angle;
      req_start_stop = toggle;
      do @(posedge clock); while (req_stall);
      predicted = predict_tick(angle, toggle);
      pending_words.push_back(typed ? typed_word : predicted);
      ticks_sent++;
   endtask

   task automatic random_tick();
      logic toggle;
      logic [AngleWidth-1:0] angle;
      phase_type next_ph;
      int pick;
      case (sw_phase)
         PH_STOP:
            toggle = ($urandom_range(0, 2) == 0);
         PH_R_HOLD, PH_R_TAIL, PH_L_HOLD, PH_L_TAIL:
            // long pulses are cut short by a stop
            if (cfg_now.kick_ticks == '0 || cfg_now.kick_ticks > 16'd16)
               toggle = ($urandom_range(0, 7) == 0);
            else
               toggle = ($urandom_range(0, 99) == 0);
         default:
            toggle = ($urandom_range(0, 59) == 0);
      endcase
      next_ph = toggle ? ((sw_phase == PH_STOP) ? PH_WATCH : PH_STOP) : sw_phase;
      pick = $urandom_range(0, 9);
      if (next_ph == PH_WATCH && sample_ticks + 16'd1 >= cfg_now.sample_divider && pick < 8)
         angle = next_swing_sample();
      else if (pick == 9)
         angle = ($urandom_range(0, 1) == 1) ? '1 : '0;
      else
         angle = AngleWidth'($urandom_range(0, 4095));
      send_tick(angle, toggle, 1'b0, '0);
   endtask

   task automatic apply_settings(input cfg_type c);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = CSR_UPRIGHT_ANGLE;
      csr_data = CsrDataWidth'(c.upright_angle);
      @(negedge clock);
      csr_index = CSR_BAND_OFFSET;
      csr_data = CsrDataWidth'(c.band_offset);
      @(negedge clock);
      csr_index = CSR_KICK_LEVEL;
      csr_data = CsrDataWidth'(c.kick_level);
      @(negedge clock);
      csr_index = CSR_KICK_TICKS;
      csr_data = c.kick_ticks;
      @(negedge clock);
      csr_index = CSR_SAMPLE_DIVIDER;
      csr_data = c.sample_divider;
      @(negedge clock);
      csr_write_enable = 1'b0;
      cfg_now = c;
   endtask

   task automatic drain_words();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_bursts_on && $urandom_range(0, 5) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 3)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_words
      result_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.motor_drive = rsp_motor_drive;
         got.drive_written = rsp_drive_written;
         got.run_phase = rsp_run_phase;
         words_checked++;
         if (got.drive_written === 1'b1 && got.motor_drive != '0)
            drive_pulses++;
         if (pending_words.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected word: drive %0d written %0b phase %0d", $time,
                     got.motor_drive, got.drive_written, got.run_phase);
         end else begin
            want = pending_words.pop_front();
            if (got.motor_drive !== want.motor_drive
                || got.drive_written !== want.drive_written
                || got.run_phase !== want.run_phase) begin
               mismatches++;
               $display("%0t: expected drive %0d written %0b phase %0d,",
                        $time, want.motor_drive, want.drive_written, want.run_phase,
                        " got drive %0d written %0b phase %0d",
                        got.motor_drive, got.drive_written, got.run_phase);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
         $display("%0t: no progress for %0d cycles", $time, QuietLimit);
         $display("tb NOT OK");
         $finish;
      end
   end

   initial begin
      cfg_type plan [PhaseCount];
      reset = 1'b1;
      req_valid = 1'b0;
      req_angle = '0;
      req_start_stop = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_UPRIGHT_ANGLE;
      csr_data = '0;
      idle_on = 1'b1;
      stall_bursts_on = 1'b1;
      mismatches = 0;
      ticks_sent = 0;
      words_checked = 0;
      drive_pulses = 0;
      quiet_cycles = 0;
      cfg_now.upright_angle = UprightAngleReset;
      cfg_now.band_offset = BandOffsetReset;
      cfg_now.kick_level = KickLevelReset;
      cfg_now.kick_ticks = KickTicksReset;
      cfg_now.sample_divider = SampleDividerReset;
      sw_phase = PH_STOP;
      sample_ticks = '0;
      pulse_left = '0;
      angle_hist[0] = '0;
      angle_hist[1] = '0;
      angle_hist[2] = '0;
      drive_now = '0;

      // directed: band 1548..2548, sample every tick, one-tick pulses at full level
      swing_rows[0]  = {12'd0,    1'b0, 1'b1, 8'sd0,    1'b1, PH_STOP};
      swing_rows[1]  = {12'd4095, 1'b1, 1'b1, 8'sd0,    1'b0, PH_WATCH};
      swing_rows[2]  = {12'd3000, 1'b0, 1'b0, 8'sd0,    1'b0, PH_STOP};
      swing_rows[3]  = {12'd3500, 1'b0, 1'b0, 8'sd0,    1'b0, PH_STOP};
      swing_rows[4]  = {12'd2048, 1'b0, 1'b1, 8'sd127,  1'b1, PH_R_HOLD};
      swing_rows[5]  = {12'd0,    1'b0, 1'b0, 8'sd0,    1'b0, PH_STOP};
      swing_rows[6]  = {12'd4095, 1'b0, 1'b1, -8'sd127, 1'b1, PH_R_TAIL};
      swing_rows[7]  = {12'd2048, 1'b0, 1'b0, 8'sd0,    1'b0, PH_STOP};
      swing_rows[8]  = {12'd100,  1'b0, 1'b0, 8'sd0,    1'b0, PH_STOP};
      swing_rows[9]  = {12'd1000, 1'b0, 1'b0, 8'sd0,    1'b0, PH_STOP};
      swing_rows[10] = {12'd0,    1'b0, 1'b0, 8'sd0,    1'b0, PH_STOP};
      swing_rows[11] = {12'd4095, 1'b0, 1'b1, -8'sd127, 1'b1, PH_L_HOLD};
      swing_rows[12] = {12'd4095, 1'b1, 1'b1, 8'sd0,    1'b1, PH_STOP};
      swing_rows[13] = {12'd4095, 1'b1, 1'b0, 8'sd0,    1'b0, PH_STOP};
      // samples on and just past the upper threshold
      swing_rows[14] = {12'd2549, 1'b0, 1'b0, 8'sd0,    1'b0, PH_STOP};
      swing_rows[15] = {12'd2548, 1'b0, 1'b0, 8'sd0,    1'b0, PH_STOP};
      swing_rows[16] = {12'd2600, 1'b0, 1'b0, 8'sd0,    1'b0, PH_STOP};

      plan[0] = make_settings(2048, 500, 35, 3, 2);
      plan[1] = make_settings(0, 0, 0, 1, 1);
      plan[2] = make_settings(4095, 2047, 100, 2, 0);
      // zero pulse length wraps the countdown, stops end those kicks
      plan[3] = make_settings(0, 2047, 127, 0, 3);
      plan[4] = make_settings(4095, 0, 1, 65535, 1);
      plan[5] = make_settings(1000, 300, 64, 4, 65535);
      for (int p = 6; p < PhaseCount; p++)
         plan[p] = make_settings($urandom_range(0, 4095), $urandom_range(0, 1200),
                                 $urandom_range(0, 127), $urandom_range(1, 5),
                                 $urandom_range(0, 4));

      repeat (5) @(negedge clock);
      reset = 1'b0;

      apply_settings(make_settings(2048, 500, 127, 1, 0));
      for (int i = 0; i < RowCount; i++)
         send_tick(swing_rows[i].angle, swing_rows[i].toggle, swing_rows[i].typed,
                   swing_rows[i].want);

      for (int p = 0; p < PhaseCount; p++) begin
         drain_words();
         apply_settings(plan[p]);
         idle_on = (p < PhaseCount - 2) && (p != 3);
         stall_bursts_on = idle_on;
         repeat (TicksPerPhase) random_tick();
      end
      drain_words();
      repeat (4) @(posedge clock);

      $display("covered %0d ticks over %0d register settings, %0d words checked",
               ticks_sent, PhaseCount + 1, words_checked);
      $display("%0d kick pulses driven, %0d mismatches", drive_pulses, mismatches);
      if (mismatches == 0 && pending_words.size() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
